### hdl/sorted_key_table_core_assert.svh
// ----------------------------------------------------------------------------
// sorted_key_table_core assertion macros
// shorthand for clocked, reset-qualified concurrent checks
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_TABLE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SKT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SKT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### hdl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// shared widths, operation and status codes, and controller commands
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned KeyW    = 16;
  localparam int unsigned PldW    = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 5;

  localparam int unsigned DefDepth       = 16;
  localparam int unsigned DefPayloadBits = 32;

  localparam logic [FuncW-1:0] OP_INSERT = 2'd0;
  localparam logic [FuncW-1:0] OP_REMOVE = 2'd1;
  localparam logic [FuncW-1:0] OP_CLEAR  = 2'd2;

  localparam logic [StatusW-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [StatusW-1:0] STAT_REMOVED   = 3'd1;
  localparam logic [StatusW-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [StatusW-1:0] STAT_FULL      = 3'd3;
  localparam logic [StatusW-1:0] STAT_DUPLICATE = 3'd4;
  localparam logic [StatusW-1:0] STAT_CLEARED   = 3'd5;

  typedef struct packed {
    logic capture;  // latch item and compare vectors
    logic execute;  // update table and load result register
  } skt_cmd_t;

endpackage

### hdl/skt_in_if.sv
// ----------------------------------------------------------------------------
// skt_in_if
// request channel: operation, key and payload with valid/ready
// ----------------------------------------------------------------------------
interface skt_in_if;
  import skt_pkg::*;

  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [KeyW-1:0]  key;
  logic [PldW-1:0]  payload;

  modport source (output valid, func, key, payload, input ready);
  modport sink (input valid, func, key, payload, output ready);
endinterface

### hdl/skt_out_if.sv
// ----------------------------------------------------------------------------
// skt_out_if
// result channel: status, key, payload and count with valid/ready
// ----------------------------------------------------------------------------
interface skt_out_if;
  import skt_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [KeyW-1:0]    out_key;
  logic [PldW-1:0]    out_payload;
  logic [CountW-1:0]  count;

  modport source (output valid, status, out_key, out_payload, count, input ready);
  modport sink (input valid, status, out_key, out_payload, count, output ready);
endinterface

### hdl/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl
// two-state sequencer: capture an item, then execute it into the result reg
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output skt_pkg::skt_cmd_t cmd_o
);
  import skt_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    in_ready_o    = (state_q == S_IDLE);
    cmd_o.capture = in_valid_i && in_ready_o;
    cmd_o.execute = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.capture) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_o.execute) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

### hdl/skt_dpath.sv
// ----------------------------------------------------------------------------
// skt_dpath
// row of key/payload cells with per-cell compare and one-slot shift
// ----------------------------------------------------------------------------
module skt_dpath #(
  parameter int unsigned DEPTH        = skt_pkg::DefDepth,
  parameter int unsigned PAYLOAD_BITS = skt_pkg::DefPayloadBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  skt_pkg::skt_cmd_t              cmd_i,
  input  logic [skt_pkg::FuncW-1:0]      func_i,
  input  logic [skt_pkg::KeyW-1:0]       key_i,
  input  logic [skt_pkg::PldW-1:0]       payload_i,
  output logic [skt_pkg::StatusW-1:0]    status_o,
  output logic [skt_pkg::KeyW-1:0]       out_key_o,
  output logic [skt_pkg::PldW-1:0]       out_payload_o,
  output logic [skt_pkg::CountW-1:0]     count_o
);
  import skt_pkg::*;

  // only the low bits that fit both the field and the parameter are kept
  localparam int unsigned KeepW = (PAYLOAD_BITS < PldW) ? PAYLOAD_BITS : PldW;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(DEPTH);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  logic [KeyW-1:0]  key_q   [DEPTH];
  logic [KeepW-1:0] pld_q   [DEPTH];
  logic [KeyW-1:0]  key_d   [DEPTH];
  logic [KeepW-1:0] pld_d   [DEPTH];
  logic [CntW-1:0]  cnt_q, cnt_d;

  // captured item and compare vectors
  logic [FuncW-1:0] op_q;
  logic [KeyW-1:0]  ikey_q;
  logic [KeepW-1:0] ipld_q;
  logic [DEPTH-1:0] lt_q, eq_q, lt_d, eq_d;

  logic [StatusW-1:0] res_status_q, res_status_d;
  logic [KeyW-1:0]    res_key_q, res_key_d;
  logic [KeepW-1:0]   res_pld_q, res_pld_d;

  logic             hit;
  logic             full;
  logic             do_ins;
  logic             do_rem;
  logic [KeepW-1:0] got_pld;

  // per-cell compare against the incoming key
  always_comb begin
    for (int unsigned i = 0; i < DEPTH; i++) begin
      lt_d[i] = (CntW'(i) < cnt_q) && (key_q[i] < key_i);
      eq_d[i] = (CntW'(i) < cnt_q) && (key_q[i] == key_i);
    end
  end

  always_comb begin
    hit     = |eq_q;
    full    = (cnt_q == CntMax);
    got_pld = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (eq_q[i]) got_pld = got_pld | pld_q[i];
    end

    do_ins = 1'b0;
    do_rem = 1'b0;
    cnt_d  = cnt_q;
    res_status_d = STAT_NOT_FOUND;
    res_key_d    = '0;
    res_pld_d    = '0;
    unique case (op_q)
      OP_INSERT: begin
        if (hit) begin
          res_status_d = STAT_DUPLICATE;
        end else if (full) begin
          res_status_d = STAT_FULL;
        end else begin
          do_ins       = 1'b1;
          cnt_d        = cnt_q + CntOne;
          res_status_d = STAT_INSERTED;
          res_key_d    = ikey_q;
          res_pld_d    = ipld_q;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          do_rem       = 1'b1;
          cnt_d        = cnt_q - CntOne;
          res_status_d = STAT_REMOVED;
          res_key_d    = ikey_q;
          res_pld_d    = got_pld;
        end
      end
      OP_CLEAR: begin
        cnt_d        = '0;
        res_status_d = STAT_CLEARED;
      end
      default: res_status_d = STAT_NOT_FOUND;
    endcase

    // insert: cells at or above the slot move up by one, slot takes new entry
    // remove: cells at or above the match take their upper neighbor
    for (int unsigned i = 0; i < DEPTH; i++) begin
      key_d[i] = key_q[i];
      pld_d[i] = pld_q[i];
      if (do_ins && !lt_q[i]) begin
        if (i == 0 || lt_q[(i == 0) ? 0 : i - 1]) begin
          key_d[i] = ikey_q;
          pld_d[i] = ipld_q;
        end else begin
          key_d[i] = key_q[(i == 0) ? 0 : i - 1];
          pld_d[i] = pld_q[(i == 0) ? 0 : i - 1];
        end
      end else if (do_rem && !lt_q[i] && (i + 1 < DEPTH)) begin
        key_d[i] = key_q[(i + 1 < DEPTH) ? i + 1 : i];
        pld_d[i] = pld_q[(i + 1 < DEPTH) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.execute) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= func_i;
      ikey_q <= key_i;
      ipld_q <= KeepW'(payload_i);
      lt_q   <= lt_d;
      eq_q   <= eq_d;
    end
    if (cmd_i.execute) begin
      for (int unsigned i = 0; i < DEPTH; i++) begin
        key_q[i] <= key_d[i];
        pld_q[i] <= pld_d[i];
      end
      res_status_q <= res_status_d;
      res_key_q    <= res_key_d;
      res_pld_q    <= res_pld_d;
    end
  end

  // count register tracks the table after execute, so it matches the result
  assign status_o      = res_status_q;
  assign out_key_o     = res_key_q;
  assign out_payload_o = PldW'(res_pld_q);
  assign count_o       = CountW'(cnt_q);
endmodule

### hdl/sorted_key_table_core.sv
// ----------------------------------------------------------------------------
// sorted_key_table_core
// bounded key/payload table kept in ascending key order
// ----------------------------------------------------------------------------
// usage
//   in_i  : request beats carry func (insert, remove by key, clear), a 16-bit
//           key and a 32-bit payload; a beat moves when valid and ready meet
//   out_o : exactly one result beat per request: status, key and payload
//           concerned, and the entry count after the operation
// timing
//   a request is taken in the idle cycle, every cell compares its key in the
//   same edge, and the execute step, once the result register is empty or
//   being taken, shifts the cells by one slot and loads the result register;
//   a new request is taken only after the previous one has committed
//   the compare register feeds the shift row
// stall
//   a waiting result does not block the next request; if the result register
//   is still full when a second request is ready to commit, that request
//   holds in its execute step until the receiver takes the pending beat
// reset
//   rst_ni empties the table, drops the result valid flag and returns the
//   sequencer to idle; cell contents are left as they are and are never read
//   before being written
// ----------------------------------------------------------------------------
module sorted_key_table_core #(
  parameter int unsigned DEPTH        = skt_pkg::DefDepth,
  parameter int unsigned PAYLOAD_BITS = skt_pkg::DefPayloadBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  skt_in_if.sink    in_i,
  skt_out_if.source out_o
);
  import skt_pkg::*;

  // commands from the sequencer into the cell row
  skt_cmd_t cmd;

  // sequencer: owns both handshakes and the result valid flag
  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  // cell row, occupancy counter and result register
  skt_dpath #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (in_i.func),
    .key_i         (in_i.key),
    .payload_i     (in_i.payload),
    .status_o      (out_o.status),
    .out_key_o     (out_o.out_key),
    .out_payload_o (out_o.out_payload),
    .count_o       (out_o.count)
  );

  // checks on the sequencer and result path
`include "sorted_key_table_core_assert.svh"

  // a request is never taken in the cycle that commits the previous one
  `SKT_ASSERT_NOW(a_cap_not_exec, cmd.capture, !cmd.execute)
  // after a request beat the block is busy for its execute step
  `SKT_ASSERT_NEXT(a_busy_after_cap, cmd.capture, !in_i.ready)
  // a commit always presents a result in the next cycle
  `SKT_ASSERT_NEXT(a_exec_gives_out, cmd.execute, out_o.valid)
  // a clear result always reports an empty table
  `SKT_ASSERT_NOW(a_clear_count, out_o.valid && (out_o.status == STAT_CLEARED), out_o.count == '0)
endmodule
